// File: rtl/assert_macros.svh
// Assertion macros used by the windowed_speed_statistic_top RTL.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies a property on the next clock edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/wss_pkg.sv
// Package for the windowed speed statistic: widths, codes and the microcode ROM.
// No dependencies.
`default_nettype none

package wss_pkg;

  // Ring depth; must be a power of two.
  localparam int DEPTH  = 256;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int SPD_W  = 16;
  localparam int HGT_W  = 20;
  localparam int WL_W   = 8;
  localparam int MTH_W  = 2;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 8;
  localparam int SUM_W  = SPD_W + PTR_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int MEM_W  = HGT_W + SPD_W;
  localparam int STEP_W = 3;

  typedef enum logic [CFG_IW-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_METHOD        = 2'd1
  } cfg_reg_e;

  localparam logic [MTH_W-1:0] METHOD_AVG    = 2'd0;
  localparam logic [MTH_W-1:0] METHOD_MAX    = 2'd1;
  localparam logic [MTH_W-1:0] METHOD_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    J_NEXT,
    J_NO_REQ,
    J_CNT_NZ,
    J_NOT_AVG,
    J_DIV_MORE,
    J_OUT_BUSY,
    J_ALWAYS
  } jmp_e;

  typedef struct packed {
    logic              accept;
    logic              issue;
    logic              accum;
    logic              div_init;
    logic              div_step;
    logic              out_load;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] ST_PRIME  = 3'd1;
  localparam logic [STEP_W-1:0] ST_LOOP   = 3'd2;
  localparam logic [STEP_W-1:0] ST_DIVSET = 3'd3;
  localparam logic [STEP_W-1:0] ST_DIV    = 3'd4;
  localparam logic [STEP_W-1:0] ST_WAIT   = 3'd5;
  localparam logic [STEP_W-1:0] ST_DONE   = 3'd6;

  // Jump taken goes to target, otherwise to the next step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{accept: 1'b0, issue: 1'b0, accum: 1'b0, div_init: 1'b0, div_step: 1'b0,
          out_load: 1'b0, jmp: J_ALWAYS, target: ST_IDLE};
    unique case (step)
      ST_IDLE: begin
        c.accept = 1'b1;
        c.jmp    = J_NO_REQ;
        c.target = ST_IDLE;
      end
      ST_PRIME: begin
        c.issue = 1'b1;
        c.jmp   = J_NEXT;
      end
      ST_LOOP: begin
        c.issue  = 1'b1;
        c.accum  = 1'b1;
        c.jmp    = J_CNT_NZ;
        c.target = ST_LOOP;
      end
      ST_DIVSET: begin
        c.div_init = 1'b1;
        c.jmp      = J_NOT_AVG;
        c.target   = ST_WAIT;
      end
      ST_DIV: begin
        c.div_step = 1'b1;
        c.jmp      = J_DIV_MORE;
        c.target   = ST_DIV;
      end
      ST_WAIT: begin
        c.jmp    = J_OUT_BUSY;
        c.target = ST_WAIT;
      end
      ST_DONE: begin
        c.out_load = 1'b1;
        c.jmp      = J_ALWAYS;
        c.target   = ST_IDLE;
      end
      default: begin
        c.jmp    = J_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/windowed_speed_statistic_top.sv
// Windowed speed statistic: ring stores, microcoded window walk and divider.
// Depends on wss_pkg and assert_macros.svh.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o) carries one speed and one height
//   sample per request; output channel (out_valid_o/out_ready_i) returns one
//   speed_result per request.
// - Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 window_length, 1 method) in the same cycle; write only while idle.
// - After reset a clearing pass zeroes all DEPTH (256) ring entries, with
//   in_ready_o low throughout. Config writes are taken during it.
// - One request at a time. The window walk reads one ring entry per cycle
//   through the memory's registered read port; the mean adds a
//   one-bit-per-cycle divider.
// - The walk reads the last N samples, the new one included (N = saturated
//   window, 1..255); the mean then runs the divider before the result load.
// - A new request is accepted only after the previous one loads its result.
// - A result waits in the output register while the receiver stalls; the
//   next request is accepted and walked meanwhile and holds before its own
//   result load until the register frees.
`default_nettype none

module windowed_speed_statistic_top
  import wss_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IW-1:0]       cfg_idx_i,
  input  wire logic [CFG_DW-1:0]       cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [SPD_W-1:0]        speed_sample_i,
  input  wire logic signed [HGT_W-1:0] height_sample_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [SPD_W-1:0]             speed_result_o
);

  logic [MEM_W-1:0] mem [DEPTH];
  logic [MEM_W-1:0] rd_q;

  logic [STEP_W-1:0] step_q, step_d;
  logic [PTR_W:0]    clr_q, clr_d;
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [WL_W-1:0]   wlen_q, wlen_d;
  logic [MTH_W-1:0]  method_q, method_d;
  logic              out_valid_q, out_valid_d;

  logic [PTR_W-1:0]        pos_q, pos_d;
  logic [PTR_W-1:0]        cnt_q, cnt_d;
  logic [PTR_W-1:0]        n_q, n_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [SPD_W-1:0]        best_spd_q, best_spd_d;
  logic signed [HGT_W-1:0] best_h_q, best_h_d;
  logic                    have_q, have_d;
  logic [PTR_W-1:0]        rem_q, rem_d;
  logic [DCNT_W-1:0]       dcnt_q, dcnt_d;
  logic [SPD_W-1:0]        res_q, res_d;

  ctrl_t                   ctrl;
  logic                    clearing;
  logic                    in_fire;
  logic                    is_avg;
  logic                    taken;
  logic [PTR_W-1:0]        n_sat;
  logic [SPD_W-1:0]        rd_spd;
  logic signed [HGT_W-1:0] rd_h;
  logic [PTR_W:0]          trial;
  logic                    ge;
  logic                    mem_we;
  logic [PTR_W-1:0]        mem_waddr;
  logic [MEM_W-1:0]        mem_wdata;

  assign ctrl     = ucode(step_q);
  assign clearing = !clr_q[PTR_W];
  assign in_ready_o = ctrl.accept && !clearing;
  assign in_fire  = in_valid_i && in_ready_o;
  assign is_avg   = (method_q != METHOD_MAX) && (method_q != METHOD_HEIGHT);
  assign rd_spd   = rd_q[SPD_W-1:0];
  assign rd_h     = signed'(rd_q[MEM_W-1:SPD_W]);
  assign out_valid_o    = out_valid_q;
  assign speed_result_o = res_q;

  always_comb begin
    if (wlen_q == '0) begin
      n_sat = PTR_W'(1);
    end else if (32'(wlen_q) > DEPTH - 1) begin
      n_sat = PTR_W'(DEPTH - 1);
    end else begin
      n_sat = PTR_W'(wlen_q);
    end
  end

  // Ring memory: one write port (clear or sample), one registered read port.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_q;
    mem_wdata = {height_sample_i, speed_sample_i};
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q[PTR_W-1:0];
      mem_wdata = '0;
    end else if (in_fire) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[pos_q];
  end

  // Sequencer
  always_comb begin
    unique case (ctrl.jmp)
      J_NEXT:     taken = 1'b0;
      J_NO_REQ:   taken = !in_fire;
      J_CNT_NZ:   taken = (cnt_q != '0);
      J_NOT_AVG:  taken = !is_avg;
      J_DIV_MORE: taken = (dcnt_q != DCNT_W'(1));
      J_OUT_BUSY: taken = out_valid_q && !out_ready_i;
      J_ALWAYS:   taken = 1'b1;
      default:    taken = 1'b1;
    endcase
    step_d = taken ? ctrl.target : step_q + STEP_W'(1);
  end

  always_comb begin
    clr_d    = clearing ? clr_q + (PTR_W+1)'(1) : clr_q;
    wlen_d   = wlen_q;
    method_d = method_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LENGTH: wlen_d   = WL_W'(cfg_wdata_i);
        REG_METHOD:        method_d = cfg_wdata_i[MTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath
  always_comb begin
    wp_d        = wp_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    sum_d       = sum_q;
    best_spd_d  = best_spd_q;
    best_h_d    = best_h_q;
    have_d      = have_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    trial       = {rem_q, sum_q[SUM_W-1]};
    ge          = (trial >= {1'b0, n_q});

    if (in_fire) begin
      wp_d       = wp_q + PTR_W'(1);
      pos_d      = wp_q + PTR_W'(1) - n_sat;
      cnt_d      = n_sat;
      n_d        = n_sat;
      sum_d      = '0;
      best_spd_d = '0;
      have_d     = 1'b0;
    end

    if (ctrl.issue && (cnt_q != '0)) begin
      pos_d = pos_q + PTR_W'(1);
      cnt_d = cnt_q - PTR_W'(1);
    end

    if (ctrl.accum) begin
      case (method_q)
        METHOD_MAX: begin
          if (rd_spd > best_spd_q) begin
            best_spd_d = rd_spd;
          end
        end
        METHOD_HEIGHT: begin
          if (!have_q || (rd_h > best_h_q)) begin
            have_d     = 1'b1;
            best_h_d   = rd_h;
            best_spd_d = rd_spd;
          end
        end
        default: sum_d = sum_q + SUM_W'(rd_spd);
      endcase
    end

    if (ctrl.div_init) begin
      rem_d  = '0;
      dcnt_d = DCNT_W'(SUM_W);
    end

    // Restoring division, one quotient bit per step; sum_q shifts into quotient.
    if (ctrl.div_step) begin
      rem_d  = ge ? PTR_W'(trial - {1'b0, n_q}) : trial[PTR_W-1:0];
      sum_d  = {sum_q[SUM_W-2:0], ge};
      dcnt_d = dcnt_q - DCNT_W'(1);
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
      res_d       = is_avg ? sum_q[SPD_W-1:0] : best_spd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      clr_q       <= '0;
      wp_q        <= '0;
      wlen_q      <= WL_W'(1);
      method_q    <= METHOD_AVG;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      clr_q       <= clr_d;
      wp_q        <= wp_d;
      wlen_q      <= wlen_d;
      method_q    <= method_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    n_q        <= n_d;
    sum_q      <= sum_d;
    best_spd_q <= best_spd_d;
    best_h_q   <= best_h_d;
    have_q     <= have_d;
    rem_q      <= rem_d;
    dcnt_q     <= dcnt_d;
    res_q      <= res_d;
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_starts_walk, in_fire, step_q == ST_PRIME, "walk did not start")
  `ASSERT_CLK(a_done_out_free, (step_q == ST_DONE) |-> !out_valid_q, "result overwritten")
  `ASSERT_CLK(a_rem_below_n, (step_q == ST_DIV) |-> (rem_q < n_q), "remainder not below N")
  `ASSERT_CLK(a_quot_fits, ((step_q == ST_DONE) && is_avg) |-> (sum_q[SUM_W-1:SPD_W] == '0),
              "mean exceeds result width")

endmodule

`default_nettype wire

// File: tb/windowed_speed_statistic_top_tb.sv
// Self-checking testbench for windowed_speed_statistic_top: directed table, then random phases.
// Results are checked against an in-bench window statistic predictor, or against the typed result of a directed row.
// Depends on wss_pkg and the windowed_speed_statistic_top RTL.
`default_nettype none

module windowed_speed_statistic_top_tb
  import wss_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 8;
  localparam int NUM_PHASES      = 10;
  localparam int PHASE_ITEMS     = 50;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int CFG_PAD_W       = CFG_DW - MTH_W;

  localparam logic [CFG_IW-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IW-1:0] REG_UNUSED_3 = 2'd3;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IW-1:0]       idx;
    logic [CFG_DW-1:0]       data;
    logic [SPD_W-1:0]        spd;
    logic signed [HGT_W-1:0] hgt;
    logic                    typed;
    logic [SPD_W-1:0]        result;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 28;
  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'hFFFF, 20'h00000, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h0000, 20'h80000, 1'b1, 16'h0000},
    '{ROW_CFG,    REG_WINDOW_LENGTH, 8'h00, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h1234, 20'h7FFFF, 1'b1, 16'h1234},
    '{ROW_CFG,    REG_WINDOW_LENGTH, 8'hFF, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'hFFFF, 20'h00001, 1'b0, 16'h0000},
    '{ROW_CFG,    REG_METHOD,        8'h01, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h0001, 20'h00000, 1'b1, 16'hFFFF},
    '{ROW_CFG,    REG_METHOD,        8'h02, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h0ABC, 20'h7FFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h0DEF, 20'h7FFFF, 1'b0, 16'h0000},
    '{ROW_CFG,    REG_METHOD,        8'h03, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h8000, 20'hFFFFF, 1'b0, 16'h0000},
    '{ROW_CFG,    REG_UNUSED_2,      8'hFF, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_CFG,    REG_UNUSED_3,      8'hFF, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h7FFF, 20'h00000, 1'b0, 16'h0000},
    '{ROW_CFG,    REG_WINDOW_LENGTH, 8'h02, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_CFG,    REG_METHOD,        8'hFE, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h0005, 20'hFFFFB, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h0006, 20'hFFFFD, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h0007, 20'hFFFFD, 1'b0, 16'h0000},
    '{ROW_CFG,    REG_WINDOW_LENGTH, 8'h03, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_CFG,    REG_METHOD,        8'hFC, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h5555, 20'h55555, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'hAAAA, 20'hAAAAA, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h0002, 20'h00000, 1'b0, 16'h0000},
    '{ROW_CFG,    REG_METHOD,        8'h01, 16'h0000, 20'h00000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 8'h00, 16'h0010, 20'h00000, 1'b0, 16'h0000}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IW-1:0]       cfg_idx_i;
  logic [CFG_DW-1:0]       cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [SPD_W-1:0]        speed_sample_i;
  logic signed [HGT_W-1:0] height_sample_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [SPD_W-1:0]        speed_result_o;

  logic [SPD_W-1:0]        speed_hist [DEPTH];
  logic signed [HGT_W-1:0] height_hist [DEPTH];
  logic [PTR_W-1:0]        hist_wptr;
  logic [WL_W-1:0]         window_len;
  logic [MTH_W-1:0]        stat_method;

  logic [SPD_W-1:0] expected_speeds [$];
  logic [SPD_W-1:0] oldest_speed;
  int               failures = 0;
  int               quiet_cycles = 0;
  bit               calm = 1'b0;
  bit               hold_off_req = 1'b0;

  windowed_speed_statistic_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .speed_sample_i (speed_sample_i),
    .height_sample_i(height_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .speed_result_o (speed_result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [SPD_W-1:0] window_statistic(input logic [SPD_W-1:0] spd,
                                                        input logic signed [HGT_W-1:0] hgt);
    int unsigned             n;
    logic [PTR_W-1:0]        pos;
    logic [SUM_W-1:0]        sum;
    logic signed [HGT_W-1:0] best;
    logic [SPD_W-1:0]        res;
    speed_hist[hist_wptr]  = spd;
    height_hist[hist_wptr] = hgt;
    hist_wptr = hist_wptr + PTR_W'(1);
    n = window_len;
    if (n == 0) begin
      n = 1;
    end else if (n >= DEPTH) begin
      n = DEPTH - 1;
    end
    pos  = hist_wptr - PTR_W'(n);
    sum  = '0;
    res  = '0;
    best = '0;
    for (int k = 0; k < n; k++) begin
      case (stat_method)
        METHOD_HEIGHT: begin
          if (k == 0 || height_hist[pos] > best) begin
            best = height_hist[pos];
            res  = speed_hist[pos];
          end
        end
        METHOD_MAX: begin
          if (speed_hist[pos] > res) begin
            res = speed_hist[pos];
          end
        end
        default: begin
          sum = sum + SUM_W'(speed_hist[pos]);
        end
      endcase
      pos = pos + PTR_W'(1);
    end
    if (stat_method != METHOD_HEIGHT && stat_method != METHOD_MAX) begin
      res = SPD_W'(sum / n);
    end
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_WINDOW_LENGTH) begin
      window_len = data[WL_W-1:0];
    end else if (idx == REG_METHOD) begin
      stat_method = data[MTH_W-1:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_sample(input logic [SPD_W-1:0] spd, input logic signed [HGT_W-1:0] hgt,
                             input logic typed, input logic [SPD_W-1:0] typed_result);
    logic [SPD_W-1:0] predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    speed_sample_i  <= spd;
    height_sample_i <= hgt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = window_statistic(spd, hgt);
    expected_speeds.push_back(typed ? typed_result : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int                      win;
    logic [MTH_W-1:0]        meth;
    logic [SPD_W-1:0]        spd;
    logic signed [HGT_W-1:0] hgt;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    speed_sample_i  = '0;
    height_sample_i = '0;
    for (int k = 0; k < DEPTH; k++) begin
      speed_hist[k]  = '0;
      height_hist[k] = '0;
    end
    hist_wptr   = '0;
    window_len  = 8'd1;
    stat_method = METHOD_AVG;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NUM_DIR_ROWS; r++) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        drain_requests();
        write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
      end else begin
        send_sample(DIR_ROWS[r].spd, DIR_ROWS[r].hgt, DIR_ROWS[r].typed, DIR_ROWS[r].result);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_requests();
      case (ph)
        0: begin
          win  = DEPTH - 1;
          meth = METHOD_MAX;
        end
        1: begin
          win  = 0;
          meth = METHOD_HEIGHT;
        end
        2: begin
          win  = DEPTH - 1;
          meth = METHOD_AVG;
        end
        3: begin
          win  = 4;
          meth = METHOD_AVG;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: win = 0;
            1: win = DEPTH - 1;
            2: win = $urandom_range(0, DEPTH - 1);
            default: win = $urandom_range(1, 16);
          endcase
          meth = MTH_W'($urandom_range(0, 3));
        end
      endcase
      if (ph == NUM_PHASES - 1) begin
        calm = 1'b1;
      end
      write_reg(REG_WINDOW_LENGTH, CFG_DW'(win));
      write_reg(REG_METHOD, {CFG_PAD_W'($urandom), meth});
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_DW'($urandom));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == 10) begin
          hold_off_req = 1'b1;
        end
        if (ph == 4 && i == 20) begin
          drain_requests();
        end
        case ($urandom_range(0, 9))
          0: spd = '0;
          1: spd = '1;
          default: spd = SPD_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0: hgt = 20'sh7FFFF;
          1: hgt = 20'sh80000;
          2, 3, 4: hgt = HGT_W'($urandom_range(0, 3));
          default: hgt = HGT_W'($urandom);
        endcase
        send_sample(spd, hgt, 1'b0, '0);
      end
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS windowed_speed_statistic_top");
    end else begin
      $display("FAIL windowed_speed_statistic_top");
    end
    $finish;
  end

  initial begin : receiver
    bit held_off;
    held_off    = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_speeds.size() == 0) begin
        $error("speed_result: no request pending, actual %h", speed_result_o);
        failures++;
      end else begin
        oldest_speed = expected_speeds.pop_front();
        if (speed_result_o !== oldest_speed) begin
          $error("speed_result: expected %h, actual %h", oldest_speed, speed_result_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL windowed_speed_statistic_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/wss_pkg.sv
rtl/windowed_speed_statistic_top.sv
tb/windowed_speed_statistic_top_tb.sv
